@@ rtl/core/cube_map_normal_texel_assert.svh @@
// ----------------------------------------------------------------------------
// Cube map normal texel assertion macros
// Shared concurrent check forms for the texel pipeline.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_NORMAL_TEXEL_ASSERT_SVH
`define CUBE_MAP_NORMAL_TEXEL_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define NLT_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define NLT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/nlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Normal texel package
// Fixed-point widths, face codes and word types of the texel pipeline.
// ----------------------------------------------------------------------------
package nlt_pkg;

   localparam int FRAC_W      = 16;
   localparam int ONE_Q16     = 65536;
   localparam int FACE_W      = 3;
   localparam int POS_W       = 10;
   localparam int CFG_W       = 11;
   localparam int COORD_NUM_W = POS_W + 1 + FRAC_W;
   localparam int COORD_QUO_W = COORD_NUM_W;
   localparam int VEC_W       = COORD_QUO_W + 1;
   localparam int MAG_W       = VEC_W - 1;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int LEN2_W      = SQ_W + 2;
   localparam int ROOT_W      = LEN2_W / 2;
   localparam int NORM_NUM_W  = MAG_W + FRAC_W;
   localparam int NORM_QUO_W  = FRAC_W + 1;
   localparam int BYTE_W      = 8;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic                    no_face;
   } vec3_type;

   typedef struct packed {
      vec3_type          vec;
      logic [ROOT_W-1:0] root;
   } vec_word_type;

endpackage

@@ rtl/core/nlt_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module nlt_div #(
   parameter int NUM_W  = 27,
   parameter int DEN_W  = 11,
   parameter int QUO_W  = 27,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              run,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic              valid_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];
   logic [REM_W-1:0]  rem_ff   [QUO_W-1];
   logic [DEN_W-1:0]  den_ff   [QUO_W-1];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int SH = QUO_W - 1 - i;
      logic              src_valid;
      logic [REM_W-1:0]  src_rem;
      logic [DEN_W-1:0]  src_den;
      logic [QUO_W-1:0]  src_quo;
      logic [SIDE_W-1:0] src_side;
      logic [REM_W-1:0]  dvs;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (i == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rem   = REM_W'(in_num);
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_side  = in_side;
      end else begin : g_body
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_den   = den_ff[i-1];
         assign src_quo   = quo_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      always_comb begin
         dvs    = REM_W'(src_den) << SH;
         take   = (src_rem >= dvs);
         rem_in = take ? (src_rem - dvs) : src_rem;
         quo_in = src_quo | (QUO_W'(take) << SH);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (run) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (run) begin
            quo_ff[i]  <= quo_in;
            side_ff[i] <= src_side;
         end
      end

      if (i < QUO_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (run) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= src_den;
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

@@ rtl/core/nlt_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor root, one root bit per register stage.
// ----------------------------------------------------------------------------
module nlt_isqrt #(
   parameter int VAL_W  = 56,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 run,
   input  logic                 in_valid,
   input  logic [VAL_W-1:0]     in_val,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [VAL_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int RT_W  = VAL_W / 2;
   localparam int REM_W = RT_W + 2;

   logic              valid_ff [RT_W];
   logic [RT_W-1:0]   root_ff  [RT_W];
   logic [SIDE_W-1:0] side_ff  [RT_W];
   logic [REM_W-1:0]  rem_ff   [RT_W-1];
   logic [VAL_W-1:0]  val_ff   [RT_W-1];

   for (genvar i = 0; i < RT_W; i++) begin : g_stage
      localparam int SH = RT_W - 1 - i;
      logic              src_valid;
      logic [REM_W-1:0]  src_rem;
      logic [VAL_W-1:0]  src_val;
      logic [RT_W-1:0]   src_root;
      logic [SIDE_W-1:0] src_side;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [RT_W-1:0]   root_in;

      if (i == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_val   = in_val;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_body
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_val   = val_ff[i-1];
         assign src_root  = root_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      // bring down the next two bits and test root*4+1
      always_comb begin
         rem_sh  = {src_rem[REM_W-3:0], src_val[2*SH+1 -: 2]};
         trial   = {src_root, 2'b01};
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {src_root[RT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (run) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (run) begin
            root_ff[i] <= root_in;
            side_ff[i] <= src_side;
         end
      end

      if (i < RT_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (run) begin
               rem_ff[i] <= rem_in;
               val_ff[i] <= src_val;
            end
         end
      end
   end

   assign out_valid = valid_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

@@ rtl/core/nlt_coord.sv @@
// ----------------------------------------------------------------------------
// Texel centre coordinates
// Clamps the face size and divides (2*pos+1) << 16 by it for column and row.
// ----------------------------------------------------------------------------
module nlt_coord #(
   parameter int MAX_FACE_SIZE = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              run,
   input  logic                              in_valid,
   input  nlt_pkg::face_type                 in_face,
   input  logic [nlt_pkg::POS_W-1:0]         in_column,
   input  logic [nlt_pkg::POS_W-1:0]         in_row,
   input  logic [nlt_pkg::CFG_W-1:0]         face_size,
   output logic                              out_valid,
   output nlt_pkg::face_type                 out_face,
   output logic                              out_no_face,
   output logic [nlt_pkg::COORD_QUO_W-1:0]   out_s_quo,
   output logic [nlt_pkg::COORD_QUO_W-1:0]   out_t_quo
);
   import nlt_pkg::*;

   localparam int DEN_W  = $clog2(MAX_FACE_SIZE + 1);
   localparam int WIDE_W = 13;

   logic [WIDE_W-1:0]      size_wide;
   logic [DEN_W-1:0]       size;
   logic [COORD_NUM_W-1:0] s_num;
   logic [COORD_NUM_W-1:0] t_num;
   logic                   no_face;
   logic                   s_valid;
   logic                   t_valid;
   logic [FACE_W-1:0]      s_side;

   always_comb begin
      size_wide = WIDE_W'(face_size);
      if (face_size == '0) begin
         size = DEN_W'(1);
      end else if (size_wide > WIDE_W'(MAX_FACE_SIZE)) begin
         size = DEN_W'(MAX_FACE_SIZE);
      end else begin
         size = DEN_W'(size_wide);
      end
      s_num   = {in_column, 1'b1, {FRAC_W{1'b0}}};
      t_num   = {in_row, 1'b1, {FRAC_W{1'b0}}};
      no_face = (in_face > FACE_NEG_Z);
   end

   nlt_div #(
      .NUM_W (COORD_NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (COORD_QUO_W),
      .SIDE_W(FACE_W)
   ) u_div_s (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .in_valid (in_valid),
      .in_num   (s_num),
      .in_den   (size),
      .in_side  (in_face),
      .out_valid(s_valid),
      .out_quo  (out_s_quo),
      .out_side (s_side)
   );

   nlt_div #(
      .NUM_W (COORD_NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (COORD_QUO_W),
      .SIDE_W(1)
   ) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .in_valid (in_valid),
      .in_num   (t_num),
      .in_den   (size),
      .in_side  (no_face),
      .out_valid(t_valid),
      .out_quo  (out_t_quo),
      .out_side (out_no_face)
   );

   assign out_valid = s_valid & t_valid;
   assign out_face  = face_type'(s_side);

endmodule

@@ rtl/core/nlt_vec.sv @@
// ----------------------------------------------------------------------------
// Face vector and length
// Places s and t on the face, squares and sums, and takes the floor root.
// ----------------------------------------------------------------------------
module nlt_vec (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             run,
   input  logic                             in_valid,
   input  nlt_pkg::face_type                in_face,
   input  logic                             in_no_face,
   input  logic [nlt_pkg::COORD_QUO_W-1:0]  in_s_quo,
   input  logic [nlt_pkg::COORD_QUO_W-1:0]  in_t_quo,
   output logic                             out_valid,
   output nlt_pkg::vec_word_type            out_word
);
   import nlt_pkg::*;

   localparam int SIDE_W = $bits(vec3_type);

   logic signed [VEC_W-1:0] s_val;
   logic signed [VEC_W-1:0] t_val;
   logic signed [VEC_W-1:0] one_val;
   vec3_type                map_in;
   vec3_type                map_ff;
   logic                    map_valid_ff;
   logic [MAG_W-1:0]        mag_x;
   logic [MAG_W-1:0]        mag_y;
   logic [MAG_W-1:0]        mag_z;
   logic [SQ_W-1:0]         sq_x_ff;
   logic [SQ_W-1:0]         sq_y_ff;
   logic [SQ_W-1:0]         sq_z_ff;
   vec3_type                sq_vec_ff;
   logic                    sq_valid_ff;
   logic [LEN2_W-1:0]       len2_in;
   logic [LEN2_W-1:0]       len2_ff;
   vec3_type                len_vec_ff;
   logic                    len_valid_ff;
   logic [SIDE_W-1:0]       root_side;
   logic [ROOT_W-1:0]       root;

   always_comb begin
      one_val = VEC_W'(ONE_Q16);
      s_val   = signed'({1'b0, in_s_quo}) - one_val;
      t_val   = signed'({1'b0, in_t_quo}) - one_val;
      map_in.no_face = in_no_face;
      case (in_face)
         FACE_POS_X: begin
            map_in.x = one_val;  map_in.y = -t_val;   map_in.z = -s_val;
         end
         FACE_NEG_X: begin
            map_in.x = -one_val; map_in.y = -t_val;   map_in.z = s_val;
         end
         FACE_POS_Y: begin
            map_in.x = s_val;    map_in.y = one_val;  map_in.z = t_val;
         end
         FACE_NEG_Y: begin
            map_in.x = s_val;    map_in.y = -one_val; map_in.z = -t_val;
         end
         FACE_POS_Z: begin
            map_in.x = s_val;    map_in.y = -t_val;   map_in.z = one_val;
         end
         FACE_NEG_Z: begin
            map_in.x = -s_val;   map_in.y = -t_val;   map_in.z = -one_val;
         end
         default: begin
            // no face: keep a unit vector so the root stays sane, zeroed later
            map_in.x = one_val;  map_in.y = '0;       map_in.z = '0;
         end
      endcase
   end

   always_comb begin
      mag_x   = map_ff.x[VEC_W-1] ? MAG_W'(-map_ff.x) : MAG_W'(map_ff.x);
      mag_y   = map_ff.y[VEC_W-1] ? MAG_W'(-map_ff.y) : MAG_W'(map_ff.y);
      mag_z   = map_ff.z[VEC_W-1] ? MAG_W'(-map_ff.z) : MAG_W'(map_ff.z);
      len2_in = LEN2_W'(sq_x_ff) + LEN2_W'(sq_y_ff) + LEN2_W'(sq_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         len_valid_ff <= 1'b0;
      end else if (run) begin
         map_valid_ff <= in_valid;
         sq_valid_ff  <= map_valid_ff;
         len_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         map_ff     <= map_in;
         sq_x_ff    <= SQ_W'(mag_x) * SQ_W'(mag_x);
         sq_y_ff    <= SQ_W'(mag_y) * SQ_W'(mag_y);
         sq_z_ff    <= SQ_W'(mag_z) * SQ_W'(mag_z);
         sq_vec_ff  <= map_ff;
         len2_ff    <= len2_in;
         len_vec_ff <= sq_vec_ff;
      end
   end

   nlt_isqrt #(
      .VAL_W (LEN2_W),
      .SIDE_W(SIDE_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .in_valid (len_valid_ff),
      .in_val   (len2_ff),
      .in_side  (len_vec_ff),
      .out_valid(out_valid),
      .out_root (root),
      .out_side (root_side)
   );

   assign out_word.vec  = vec3_type'(root_side);
   assign out_word.root = root;

endmodule

@@ rtl/core/nlt_norm.sv @@
// ----------------------------------------------------------------------------
// Normalize and pack
// Divides each component by the root and maps it to an unsigned byte.
// ----------------------------------------------------------------------------
module nlt_norm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         run,
   input  logic                         in_valid,
   input  nlt_pkg::vec_word_type        in_word,
   output logic                         out_valid,
   output logic [nlt_pkg::BYTE_W-1:0]   out_red,
   output logic [nlt_pkg::BYTE_W-1:0]   out_green,
   output logic [nlt_pkg::BYTE_W-1:0]   out_blue
);
   import nlt_pkg::*;

   localparam int BIAS_W  = FRAC_W + 2;
   localparam int SCALE_W = BIAS_W + BYTE_W;

   function automatic logic [BYTE_W-1:0] to_byte(logic [NORM_QUO_W-1:0] q, logic neg);
      logic [NORM_QUO_W-1:0] qc;
      logic [BIAS_W-1:0]     biased;
      logic [SCALE_W-1:0]    scaled;
      qc     = (q > NORM_QUO_W'(ONE_Q16)) ? NORM_QUO_W'(ONE_Q16) : q;
      biased = neg ? (BIAS_W'(ONE_Q16) - BIAS_W'(qc)) : (BIAS_W'(ONE_Q16) + BIAS_W'(qc));
      // times 255, then drop 17 bits
      scaled = (SCALE_W'(biased) << BYTE_W) - SCALE_W'(biased);
      return scaled[SCALE_W-2 -: BYTE_W];
   endfunction

   logic [MAG_W-1:0]      mag_x_ff;
   logic [MAG_W-1:0]      mag_y_ff;
   logic [MAG_W-1:0]      mag_z_ff;
   logic [2:0]            neg_ff;
   logic                  no_face_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic                  abs_valid_ff;
   logic                  qx_valid;
   logic                  qy_valid;
   logic                  qz_valid;
   logic [NORM_QUO_W-1:0] qx;
   logic [NORM_QUO_W-1:0] qy;
   logic [NORM_QUO_W-1:0] qz;
   logic [1:0]            x_side;
   logic                  y_neg;
   logic                  z_neg;
   logic                  out_valid_ff;
   logic [BYTE_W-1:0]     red_ff;
   logic [BYTE_W-1:0]     green_ff;
   logic [BYTE_W-1:0]     blue_ff;
   logic [BYTE_W-1:0]     red_in;
   logic [BYTE_W-1:0]     green_in;
   logic [BYTE_W-1:0]     blue_in;

   always_ff @(posedge clock) begin
      if (run) begin
         mag_x_ff   <= in_word.vec.x[VEC_W-1] ? MAG_W'(-in_word.vec.x) : MAG_W'(in_word.vec.x);
         mag_y_ff   <= in_word.vec.y[VEC_W-1] ? MAG_W'(-in_word.vec.y) : MAG_W'(in_word.vec.y);
         mag_z_ff   <= in_word.vec.z[VEC_W-1] ? MAG_W'(-in_word.vec.z) : MAG_W'(in_word.vec.z);
         neg_ff     <= {in_word.vec.z[VEC_W-1], in_word.vec.y[VEC_W-1], in_word.vec.x[VEC_W-1]};
         no_face_ff <= in_word.vec.no_face;
         root_ff    <= in_word.root;
      end
   end

   nlt_div #(
      .NUM_W (NORM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NORM_QUO_W), .SIDE_W(2)
   ) u_div_x (
      .clock(clock), .reset(reset), .run(run), .in_valid(abs_valid_ff),
      .in_num({mag_x_ff, {FRAC_W{1'b0}}}), .in_den(root_ff),
      .in_side({no_face_ff, neg_ff[0]}),
      .out_valid(qx_valid), .out_quo(qx), .out_side(x_side)
   );

   nlt_div #(
      .NUM_W (NORM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NORM_QUO_W), .SIDE_W(1)
   ) u_div_y (
      .clock(clock), .reset(reset), .run(run), .in_valid(abs_valid_ff),
      .in_num({mag_y_ff, {FRAC_W{1'b0}}}), .in_den(root_ff), .in_side(neg_ff[1]),
      .out_valid(qy_valid), .out_quo(qy), .out_side(y_neg)
   );

   nlt_div #(
      .NUM_W (NORM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NORM_QUO_W), .SIDE_W(1)
   ) u_div_z (
      .clock(clock), .reset(reset), .run(run), .in_valid(abs_valid_ff),
      .in_num({mag_z_ff, {FRAC_W{1'b0}}}), .in_den(root_ff), .in_side(neg_ff[2]),
      .out_valid(qz_valid), .out_quo(qz), .out_side(z_neg)
   );

   always_comb begin
      if (x_side[1]) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end else begin
         red_in   = to_byte(qx, x_side[0]);
         green_in = to_byte(qy, y_neg);
         blue_in  = to_byte(qz, z_neg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (run) begin
         abs_valid_ff <= in_valid;
         out_valid_ff <= qx_valid & qy_valid & qz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

@@ rtl/core/cube_map_normal_texel.sv @@
// Throughput: one word per cycle while no skid word is parked; set by the
// one-bit-per-stage divider and square root pipelines, every stage of which
// takes a new word each cycle while run is high.
// A two-entry output (holding register plus skid) keeps req_tready registered.
// Reset clears all valid bits and loads face_size with 128.
// ----------------------------------------------------------------------------
// Normalization cube map texel generator
// Streams face/column/row words in and unit direction RGB words out.
// ----------------------------------------------------------------------------
`include "cube_map_normal_texel_assert.svh"

module cube_map_normal_texel #(
   parameter int MAX_FACE_SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,   // face_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // face[2:0], column[12:3], row[22:13], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata      // red[7:0], green[15:8], blue[23:16]
);
   import nlt_pkg::*;

   logic [CFG_W-1:0]       face_size_ff;
   logic                   run;
   logic                   co_valid;
   face_type               co_face;
   logic                   co_no_face;
   logic [COORD_QUO_W-1:0] co_s_quo;
   logic [COORD_QUO_W-1:0] co_t_quo;
   logic                   vec_valid;
   vec_word_type           vec_word;
   logic                   tail_valid;
   logic [3*BYTE_W-1:0]    tail_data;
   logic [BYTE_W-1:0]      tail_red;
   logic [BYTE_W-1:0]      tail_green;
   logic [BYTE_W-1:0]      tail_blue;
   logic                   tail_take;
   logic                   rsp_free;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [3*BYTE_W-1:0]    rsp_data_ff;
   logic [3*BYTE_W-1:0]    rsp_data_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   logic [3*BYTE_W-1:0]    skid_data_ff;
   logic [3*BYTE_W-1:0]    skid_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= CFG_W'(128);
      end else if (csr_wr_en) begin
         face_size_ff <= csr_wr_data;
      end
   end

   // stall the whole pipeline only while the skid word is parked
   assign run        = !skid_valid_ff;
   assign req_tready = run;

   nlt_coord #(
      .MAX_FACE_SIZE(MAX_FACE_SIZE)
   ) u_coord (
      .clock      (clock),
      .reset      (reset),
      .run        (run),
      .in_valid   (req_tvalid),
      .in_face    (face_type'(req_tdata[2:0])),
      .in_column  (req_tdata[12:3]),
      .in_row     (req_tdata[22:13]),
      .face_size  (face_size_ff),
      .out_valid  (co_valid),
      .out_face   (co_face),
      .out_no_face(co_no_face),
      .out_s_quo  (co_s_quo),
      .out_t_quo  (co_t_quo)
   );

   nlt_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (co_valid),
      .in_face   (co_face),
      .in_no_face(co_no_face),
      .in_s_quo  (co_s_quo),
      .in_t_quo  (co_t_quo),
      .out_valid (vec_valid),
      .out_word  (vec_word)
   );

   nlt_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .in_valid (vec_valid),
      .in_word  (vec_word),
      .out_valid(tail_valid),
      .out_red  (tail_red),
      .out_green(tail_green),
      .out_blue (tail_blue)
   );

   assign tail_data = {tail_blue, tail_green, tail_red};
   assign tail_take = run && tail_valid;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (tail_take) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tail_data;
         end else begin
            // park the word behind the held one
            skid_valid_in = 1'b1;
            skid_data_in  = tail_data;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `NLT_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid word without held word")
   `NLT_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_tready, !skid_valid_ff, "skid did not drain")
   `NLT_ASSERT_NEXT(a_tail_holds, !run, tail_valid == $past(tail_valid), "tail moved while stalled")

endmodule

@@ tb/tb_cube_map_normal_texel.sv @@
// ----------------------------------------------------------------------------
// Normal texel testbench
// Drives face/column/row words through the cube map normal texel block and
// compares each RGB word with a fixed-point prediction, under random
// sender gaps, receiver stalls and face size changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class texel_scoreboard;
   logic [10:0] face_size;
   logic [23:0] rgb_queue[$];
   int          fail_count;

   function new();
      face_size  = 11'd128;
      fail_count = 0;
   endfunction

   function longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function longint centre(longint unsigned pos, longint unsigned sz);
      return longint'((((2 * pos) + 1) << 16) / sz) - 65536;
   endfunction

   function logic [7:0] comp_byte(longint c, longint unsigned root);
      longint unsigned m;
      longint unsigned q;
      longint n;
      m = (c < 0) ? longint'(-c) : c;
      q = (m << 16) / root;
      if (q > 65536) q = 65536;
      n = (c < 0) ? -longint'(q) : longint'(q);
      return 8'((unsigned'(n + 65536) * 255) >> 17);
   endfunction

   function void note_texel(logic [2:0] face, logic [9:0] col, logic [9:0] row);
      longint unsigned sz;
      longint s;
      longint t;
      longint vx;
      longint vy;
      longint vz;
      longint unsigned root;
      if (face > nlt_pkg::FACE_NEG_Z) begin
         rgb_queue.push_back(24'd0);
         return;
      end
      sz = face_size;
      if (sz == 0) sz = 1;
      if (sz > 1024) sz = 1024;
      s = centre(col, sz);
      t = centre(row, sz);
      case (face)
         nlt_pkg::FACE_POS_X: begin vx = 65536;  vy = -t;     vz = -s;     end
         nlt_pkg::FACE_NEG_X: begin vx = -65536; vy = -t;     vz = s;      end
         nlt_pkg::FACE_POS_Y: begin vx = s;      vy = 65536;  vz = t;      end
         nlt_pkg::FACE_NEG_Y: begin vx = s;      vy = -65536; vz = -t;     end
         nlt_pkg::FACE_POS_Z: begin vx = s;      vy = -t;     vz = 65536;  end
         default:             begin vx = -s;     vy = -t;     vz = -65536; end
      endcase
      root = root64(unsigned'(vx * vx) + unsigned'(vy * vy) + unsigned'(vz * vz));
      rgb_queue.push_back({comp_byte(vz, root), comp_byte(vy, root), comp_byte(vx, root)});
   endfunction

   function void check_rgb(logic [23:0] got);
      logic [23:0] want;
      if (rgb_queue.size() == 0) begin
         $error("unexpected rsp word %h", got);
         fail_count++;
         return;
      end
      want = rgb_queue.pop_front();
      if (got[7:0] !== want[7:0]) begin
         $error("red: expected %0d, got %0d", want[7:0], got[7:0]);
         fail_count++;
      end
      if (got[15:8] !== want[15:8]) begin
         $error("green: expected %0d, got %0d", want[15:8], got[15:8]);
         fail_count++;
      end
      if (got[23:16] !== want[23:16]) begin
         $error("blue: expected %0d, got %0d", want[23:16], got[23:16]);
         fail_count++;
      end
   endfunction
endclass

module tb_cube_map_normal_texel;
   import nlt_pkg::*;

   localparam int LATENCY = 78;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // face[2:0], column[12:3], row[22:13], zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // red[7:0], green[15:8], blue[23:16]

   texel_scoreboard texels;
   int              hold_off;   // cycles the receiver must still stall
   bit              gaps_on;

   cube_map_normal_texel dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: own stall pattern, plus a long forced hold-off
   initial begin
      int phase;
      rsp_tready = 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) texels.check_rgb(rsp_tdata);
         phase++;
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (!gaps_on) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ((phase % 37) < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic send_texel(logic [2:0] face, logic [9:0] col, logic [9:0] row);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, row, col, face};
      do @(posedge clock); while (!req_tready);
      texels.note_texel(face, col, row);
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
   endtask

   // hold off the sender until the pipeline has drained
   task automatic drain();
      idle_sender();
      @(posedge clock);
      while (texels.rgb_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_size(logic [10:0] sz);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sz;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      texels.face_size = sz;
   endtask

   task automatic random_phase(int count, logic [10:0] sz);
      int burst;
      int lim;
      int gap;
      logic [2:0] f;
      lim = (sz == 0) ? 1 : ((sz > 1024) ? 1024 : sz);
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            if (gaps_on) begin
               gap = $urandom_range(0, 6);
               if (gap > 0) begin
                  idle_sender();
                  repeat (gap) @(posedge clock);
               end
            end
            burst = $urandom_range(1, 30);
         end
         burst--;
         f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         if ($urandom_range(0, 9) == 0)
            send_texel(f, 10'($urandom), 10'($urandom));
         else
            send_texel(f, 10'($urandom_range(0, lim - 1)), 10'($urandom_range(0, lim - 1)));
      end
   endtask

   initial begin
      logic [10:0] sizes[8];
      texels      = new();
      hold_off    = 0;
      gaps_on     = 1'b1;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 11'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 24'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset size, every face, corners, no-face codes
      for (int f = 0; f < 8; f++) send_texel(3'(f), 10'd0, 10'd127);
      send_texel(FACE_POS_X, 10'd127, 10'd0);
      send_texel(FACE_POS_Z, 10'd63, 10'd64);
      send_texel(FACE_NEG_Y, 10'd1023, 10'd1023);
      drain();
      write_size(11'd1);
      send_texel(FACE_POS_Y, 10'd0, 10'd0);
      send_texel(FACE_NEG_Z, 10'd1023, 10'd512);
      drain();
      write_size(11'd0);
      send_texel(FACE_NEG_X, 10'd0, 10'd1);
      drain();
      write_size(11'd2047);
      send_texel(FACE_POS_X, 10'd1023, 10'd0);
      send_texel(FACE_NEG_Z, 10'd0, 10'd1023);
      drain();
      write_size(11'd1024);
      send_texel(FACE_POS_Z, 10'd511, 10'd512);
      send_texel(FACE_NEG_Y, 10'd341, 10'd682);

      // long receiver hold-off while the sender keeps offering
      hold_off = 300;
      random_phase(200, 11'd1024);
      drain();

      sizes = '{11'd128, 11'd1, 11'd2, 11'd3, 11'd1023, 11'd1024, 11'd2047, 11'd0};
      for (int p = 0; p < 8; p++) begin
         write_size(sizes[p]);
         gaps_on = (p != 3);
         random_phase(95, sizes[p]);
         drain();
      end
      gaps_on = 1'b1;

      if (texels.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

@@ cube_map_normal_texel.f @@
+incdir+rtl/core
rtl/core/nlt_pkg.sv
rtl/core/nlt_div.sv
rtl/core/nlt_isqrt.sv
rtl/core/nlt_coord.sv
rtl/core/nlt_vec.sv
rtl/core/nlt_norm.sv
rtl/core/cube_map_normal_texel.sv
tb/tb_cube_map_normal_texel.sv
